// ===== rtl/encoder_button_menu_controller_assert.svh =====
// Assertion macros shared by the menu controller RTL.
`ifndef ENCODER_BUTTON_MENU_CONTROLLER_ASSERT_SVH
`define ENCODER_BUTTON_MENU_CONTROLLER_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define EBMC_ASSERT_HOLDS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define EBMC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ebmc_pkg.sv =====
// Types, codes and constants of the encoder and button menu controller.
package ebmc_pkg;

	localparam int VisibleRows    = 3;
	localparam int FullScaleSteps = 40;

	localparam int LevelW  = 6;
	localparam int IndexW  = 8;
	localparam int TimeW   = 32;
	localparam int MsW     = 16;
	localparam int DeltaW  = 16;
	localparam int CfgIdxW = 2;

	typedef logic [1:0] req_t;
	localparam req_t REQ_POLL      = 2'd0;
	localparam req_t REQ_SET_LEVEL = 2'd1;
	localparam req_t REQ_SET_LIST  = 2'd2;
	localparam req_t REQ_REDRAW    = 2'd3;

	typedef logic [2:0] event_t;
	localparam event_t EV_NONE   = 3'd0;
	localparam event_t EV_GAIN   = 3'd1;
	localparam event_t EV_VOLUME = 3'd2;
	localparam event_t EV_BYPASS = 3'd3;
	localparam event_t EV_LOAD   = 3'd4;

	typedef logic [CfgIdxW-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_HOLD_MS = 2'd0;
	localparam cfg_idx_t CFG_GAP_MS  = 2'd1;

	localparam logic [MsW-1:0] LongPressReset   = 16'd600;
	localparam logic [MsW-1:0] DoubleClickReset = 16'd300;
	localparam logic [LevelW-1:0] GainReset     = 6'd20;
	localparam logic [LevelW-1:0] VolumeReset   = 6'd40;

	localparam logic [LevelW-1:0] LevelMax = LevelW'(FullScaleSteps);

	typedef struct packed {
		req_t               req;
		logic [DeltaW-1:0]  delta;
		logic               down;
		logic [TimeW-1:0]   now;
		logic [LevelW-1:0]  gain;
		logic [LevelW-1:0]  volume;
		logic [IndexW-1:0]  count;
	} item_t;

	// Saturates a signed level sum to the range 0 .. full scale.
	function automatic logic [LevelW-1:0] clamp_level(input logic signed [17:0] v);
		if (v < 18'sd0) begin
			return '0;
		end else if (v > 18'(FullScaleSteps)) begin
			return LevelMax;
		end
		return v[LevelW-1:0];
	endfunction

endpackage

// ===== rtl/encoder_button_menu_controller.sv =====
// Encoder and push-button menu controller: click classifier and two-screen menu.
//
//   channel  direction  handshake            word
//   in       input      in_valid / in_stall  req_type, encoder_delta, button_down, now_ms,
//                                            new_gain, new_volume, list_size
//   out      output     out_valid/out_stall  event_res, load_index, gain_now, volume_now,
//                                            list_screen, cursor_index, window_first,
//                                            editing_volume, redraw
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Every input word yields exactly one output word. A word is held in the input register;
// the single pass of compare, add and clamp logic then updates the menu state and loads
// the result register, so one word per cycle is sustained while out_stall stays low.
// Reset (arst_n low, asynchronous) restores the thresholds to 600 ms and 300 ms and the
// menu to the home screen with gain 20 and volume 40. No clearing pass is needed.
// While the result register is stalled, the input register holds its word and in_stall
// rises; the menu state only moves when a word goes into the result register.
module encoder_button_menu_controller
	import ebmc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               req_type,
	input  logic signed [DeltaW-1:0] encoder_delta,
	input  logic                     button_down,
	input  logic [TimeW-1:0]         now_ms,
	input  logic [LevelW-1:0]        new_gain,
	input  logic [LevelW-1:0]        new_volume,
	input  logic [IndexW-1:0]        list_size,

	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [2:0]               event_res,
	output logic [IndexW-1:0]        load_index,
	output logic [LevelW-1:0]        gain_now,
	output logic [LevelW-1:0]        volume_now,
	output logic                     list_screen,
	output logic [IndexW-1:0]        cursor_index,
	output logic [IndexW-1:0]        window_first,
	output logic                     editing_volume,
	output logic                     redraw,

	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CfgIdxW-1:0]       cfg_index,
	input  logic [MsW-1:0]           cfg_data
);

	`include "encoder_button_menu_controller_assert.svh"

	// Input register.
	logic  valid_s1;
	item_t item_s1;

	// Configuration.
	logic [MsW-1:0] hold_ms_q;
	logic [MsW-1:0] gap_ms_q;

	// Menu and classifier state.
	logic              held_q;
	logic [TimeW-1:0]  press_time_q;
	logic [TimeW-1:0]  release_time_q;
	logic [1:0]        pending_q;
	logic              list_q;
	logic              edit_vol_q;
	logic [LevelW-1:0] gain_q;
	logic [LevelW-1:0] volume_q;
	logic [IndexW-1:0] cursor_q;
	logic [IndexW-1:0] top_q;
	logic [IndexW-1:0] chosen_q;
	logic [IndexW-1:0] count_q;
	logic              need_draw_q;

	// Result register (the state registers supply the rest of the word).
	logic   out_valid_q;
	event_t event_q;
	logic   redraw_q;

	logic advance;

	// Next-state values.
	logic              held_d;
	logic [TimeW-1:0]  press_time_d;
	logic [TimeW-1:0]  release_time_d;
	logic [1:0]        pending_d;
	logic              list_d;
	logic              edit_vol_d;
	logic [LevelW-1:0] gain_d;
	logic [LevelW-1:0] volume_d;
	logic [IndexW-1:0] cursor_d;
	logic [IndexW-1:0] top_d;
	logic [IndexW-1:0] chosen_d;
	logic [IndexW-1:0] count_d;
	logic              need_draw_d;
	event_t            event_d;
	logic              redraw_d;

	// Classifier intermediate values.
	logic              tap_one;
	logic              tap_two;
	logic              hold_long;
	logic [1:0]        pending_rel;
	logic [TimeW-1:0]  release_rel;
	logic [TimeW-1:0]  hold_span;
	logic [TimeW-1:0]  quiet_span;
	logic              delta_nz;
	logic signed [17:0] level_sum;
	logic signed [17:0] cursor_sum;
	logic [IndexW-1:0] cursor_move;
	logic [IndexW:0]   window_end;

	// A word leaves the input register once the result register is free or being read.
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			item_s1.req    <= req_type;
			item_s1.delta  <= encoder_delta;
			item_s1.down   <= button_down;
			item_s1.now    <= now_ms;
			item_s1.gain   <= new_gain;
			item_s1.volume <= new_volume;
			item_s1.count  <= list_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ms_q <= LongPressReset;
			gap_ms_q  <= DoubleClickReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_HOLD_MS: hold_ms_q <= cfg_data;
				CFG_GAP_MS:  gap_ms_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Click classification: a release ends either a long press or one short click, and
	// pending clicks then resolve into a double click or, after the quiet time, a single.
	always_comb begin
		held_d         = held_q;
		press_time_d   = press_time_q;
		release_rel    = release_time_q;
		pending_rel    = pending_q;
		hold_long      = 1'b0;
		hold_span      = item_s1.now - press_time_q;
		if (item_s1.down && !held_q) begin
			press_time_d = item_s1.now;
			held_d       = 1'b1;
		end else if (!item_s1.down && held_q) begin
			held_d = 1'b0;
			if (hold_span >= TimeW'(hold_ms_q)) begin
				hold_long   = 1'b1;
				pending_rel = 2'd0;
			end else begin
				if (pending_q != 2'd3) begin
					pending_rel = pending_q + 2'd1;
				end
				release_rel = item_s1.now;
			end
		end
		quiet_span     = item_s1.now - release_rel;
		tap_one        = 1'b0;
		tap_two        = 1'b0;
		pending_d      = pending_rel;
		release_time_d = release_rel;
		if (pending_rel >= 2'd2) begin
			tap_two   = 1'b1;
			pending_d = 2'd0;
		end else if (pending_rel == 2'd1 && quiet_span >= TimeW'(gap_ms_q)) begin
			tap_one   = 1'b1;
			pending_d = 2'd0;
		end
	end

	assign delta_nz   = (item_s1.delta != '0);
	assign level_sum  = $signed({12'd0, (edit_vol_q ? volume_q : gain_q)})
		+ 18'(signed'(item_s1.delta));
	assign cursor_sum = $signed({10'd0, cursor_q}) + 18'(signed'(item_s1.delta));

	// Cursor clamped to the list; only used when the list is not empty.
	always_comb begin
		if (cursor_sum < 18'sd0) begin
			cursor_move = '0;
		end else if (cursor_sum >= $signed({10'd0, count_q})) begin
			cursor_move = count_q - IndexW'(1);
		end else begin
			cursor_move = cursor_sum[IndexW-1:0];
		end
	end

	assign window_end = {1'b0, top_q} + (IndexW+1)'(VisibleRows);

	// Menu update. Later assignments win when several events land in one poll.
	always_comb begin
		list_d      = list_q;
		edit_vol_d  = edit_vol_q;
		gain_d      = gain_q;
		volume_d    = volume_q;
		cursor_d    = cursor_q;
		top_d       = top_q;
		chosen_d    = chosen_q;
		count_d     = count_q;
		need_draw_d = need_draw_q;
		event_d     = EV_NONE;
		redraw_d    = 1'b0;
		unique case (item_s1.req)
			REQ_SET_LEVEL: begin
				gain_d      = clamp_level($signed({12'd0, item_s1.gain}));
				volume_d    = clamp_level($signed({12'd0, item_s1.volume}));
				need_draw_d = 1'b1;
			end
			REQ_SET_LIST: begin
				count_d  = item_s1.count;
				cursor_d = '0;
				top_d    = '0;
			end
			REQ_REDRAW: begin
				need_draw_d = 1'b1;
			end
			REQ_POLL: begin
				if (!list_q) begin
					if (delta_nz) begin
						if (edit_vol_q) begin
							volume_d = clamp_level(level_sum);
							event_d  = EV_VOLUME;
						end else begin
							gain_d  = clamp_level(level_sum);
							event_d = EV_GAIN;
						end
						need_draw_d = 1'b1;
					end
					if (tap_one) begin
						edit_vol_d  = !edit_vol_q;
						need_draw_d = 1'b1;
					end
					if (tap_two) begin
						event_d     = EV_BYPASS;
						need_draw_d = 1'b1;
					end
					if (hold_long) begin
						list_d      = 1'b1;
						need_draw_d = 1'b1;
					end
				end else begin
					if (delta_nz && count_q != '0) begin
						cursor_d = cursor_move;
						if (cursor_move < top_q) begin
							top_d = cursor_move;
						end else if ({1'b0, cursor_move} >= window_end) begin
							top_d = cursor_move - IndexW'(VisibleRows - 1);
						end
						need_draw_d = 1'b1;
					end
					// The entry loaded is the one under the cursor after this poll's move.
					if (tap_one && count_q != '0) begin
						chosen_d    = cursor_d;
						list_d      = 1'b0;
						event_d     = EV_LOAD;
						need_draw_d = 1'b1;
					end
					if (hold_long) begin
						list_d      = 1'b0;
						need_draw_d = 1'b1;
					end
				end
				redraw_d    = need_draw_d;
				need_draw_d = 1'b0;
			end
			default: ;
		endcase
	end

	// The classifier only moves on polls; requests leave it alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q         <= 1'b0;
			press_time_q   <= '0;
			release_time_q <= '0;
			pending_q      <= 2'd0;
		end else if (advance && item_s1.req == REQ_POLL) begin
			held_q         <= held_d;
			press_time_q   <= press_time_d;
			release_time_q <= release_time_d;
			pending_q      <= pending_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_q      <= 1'b0;
			edit_vol_q  <= 1'b0;
			gain_q      <= GainReset;
			volume_q    <= VolumeReset;
			cursor_q    <= '0;
			top_q       <= '0;
			chosen_q    <= '0;
			count_q     <= '0;
			need_draw_q <= 1'b0;
			event_q     <= EV_NONE;
			redraw_q    <= 1'b0;
		end else if (advance) begin
			list_q      <= list_d;
			edit_vol_q  <= edit_vol_d;
			gain_q      <= gain_d;
			volume_q    <= volume_d;
			cursor_q    <= cursor_d;
			top_q       <= top_d;
			chosen_q    <= chosen_d;
			count_q     <= count_d;
			need_draw_q <= need_draw_d;
			event_q     <= event_d;
			redraw_q    <= redraw_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// The state registers only change as a word enters the result register, so they
	// describe exactly the word on display.
	assign out_valid      = out_valid_q;
	assign event_res      = event_q;
	assign load_index     = chosen_q;
	assign gain_now       = gain_q;
	assign volume_now     = volume_q;
	assign list_screen    = list_q;
	assign cursor_index   = cursor_q;
	assign window_first   = top_q;
	assign editing_volume = edit_vol_q;
	assign redraw         = redraw_q;

	`EBMC_ASSERT_HOLDS(a_levels_in_range, gain_q <= LevelMax && volume_q <= LevelMax, "level beyond full scale")
	`EBMC_ASSERT_HOLDS(a_cursor_in_list, cursor_q == '0 || cursor_q < count_q, "cursor outside the list")
	`EBMC_ASSERT_HOLDS(a_cursor_in_window, top_q <= cursor_q && {1'b0, cursor_q} < window_end, "cursor outside the window")
	`EBMC_ASSERT_IMPLIES(a_event_draws, out_valid_q && event_q != EV_NONE, redraw_q, "event without redraw")
	`EBMC_ASSERT_IMPLIES(a_stall_needs_word, in_stall, valid_s1 && out_valid_q && out_stall, "input stalled without cause")

endmodule
